// ===== rtl/cuwm_pkg.sv =====
// Shared types and constants for the CPU utilization window monitor.
package cuwm_pkg;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  row;
        logic [63:0] user_ticks;
        logic [63:0] system_ticks;
        logic [63:0] idle_ticks;
        logic [63:0] iowait_ticks;
        logic        end_of_tick;
        logic [2:0]  metric;
        logic [1:0]  window;
    } cuwm_cmd_t;

    typedef struct packed {
        logic        status;
        logic [14:0] usage_avg;
    } cuwm_result_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_BADROW = 1'b1;

    localparam logic [3:0] ROW_TOTAL     = 4'd0;
    localparam logic [3:0] ROW_PARTITION = 4'd9;

    localparam int METRIC_COUNT = 5;
    localparam logic [2:0] METRIC_OVERALL = 3'd0;
    localparam logic [2:0] METRIC_IDLE    = 3'd3;
    localparam logic [2:0] METRIC_LAST    = 3'd4;

    localparam logic [1:0] WIN_300 = 2'd1;
    localparam logic [1:0] WIN_900 = 2'd2;

    localparam logic [9:0] COUNT_60  = 10'd60;
    localparam logic [9:0] COUNT_300 = 10'd300;
    localparam logic [9:0] COUNT_900 = 10'd900;

    // ceil(2^31 / k) for k = 15, 75 and 225, the window lengths divided by 4.
    localparam logic [27:0] RECIP_60  = 28'd143165577;
    localparam logic [27:0] RECIP_300 = 28'd28633116;
    localparam logic [27:0] RECIP_900 = 28'd9544372;

    localparam logic [14:0] PCT_FULL = 15'd25600;

    localparam logic [1:0] ADDR_CPU_COUNT = 2'd0;
    localparam logic [3:0] CPU_COUNT_RESET = 4'd1;

endpackage

// ===== rtl/cpu_utilization_window_monitor.sv =====
// Top level of the CPU utilization window monitor.
//
//  Channel   Signals                          Transfer
//  command   start, busy, cmd                 start high while busy low
//  result    done, result                     done high for one cycle
//  config    psel, penable, pwrite, paddr...  APB write, pready tied high
//
// A sample first updates the stored counters, reading and then writing each of the four,
// then runs five metrics through one shared shift-subtract divider of 15 steps.
// A query reads one history word per cycle from the simple dual-port history memory,
// so it reads as many words as the window length (60, 300 or 900); the average
// comes from one reciprocal multiply.
// After reset a clearing pass writes every history word, ROWS*5*2^ceil(log2(slots))
// words (51200 by default), with busy high; results cannot be held off.
module cpu_utilization_window_monitor #(
    parameter int HISTORY_SLOTS = 900,
    parameter int MAX_CPUS      = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  cuwm_pkg::cuwm_cmd_t    cmd,
    output logic                   done,
    output cuwm_pkg::cuwm_result_t result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import cuwm_pkg::*;

    localparam int ROWS   = MAX_CPUS + 2;
    localparam int RW     = $clog2(ROWS);
    localparam int SW     = $clog2(HISTORY_SLOTS);
    localparam int RMW    = $clog2(ROWS * METRIC_COUNT);
    localparam int HAW    = RMW + SW;
    localparam int HDEPTH = ROWS * METRIC_COUNT * (2 ** SW);
    localparam int LAW    = RW + 2;
    localparam int LDEPTH = 2 ** LAW;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_LRD    = 4'd2;
    localparam logic [3:0] ST_LDELTA = 4'd3;
    localparam logic [3:0] ST_MSEL   = 4'd4;
    localparam logic [3:0] ST_SCALE  = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_WR     = 4'd7;
    localparam logic [3:0] ST_QRD    = 4'd8;
    localparam logic [3:0] ST_QDRAIN = 4'd9;
    localparam logic [3:0] ST_QDIV   = 4'd10;

    logic [3:0]     state_reg, state_next;
    logic [HAW-1:0] clr_reg, clr_next;
    cuwm_cmd_t      cmd_reg, cmd_next;
    logic [RW-1:0]  ridx_reg, ridx_next;
    logic [2:0]     idx_reg, idx_next;
    logic [63:0]    d_reg [4];
    logic [63:0]    d_next [4];
    logic [65:0]    tot_reg, tot_next;
    logic [65:0]    num_reg, num_next;
    logic [81:0]    n_reg, n_next;
    logic [14:0]    q_reg, q_next;
    logic [3:0]     bit_reg, bit_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [SW-1:0]  p_reg, p_next;
    logic [RMW-1:0] rm_reg, rm_next;
    logic [9:0]     cnt_reg, cnt_next;
    logic [27:0]    recip_reg, recip_next;
    logic [24:0]    sum_reg, sum_next;
    logic           pend_reg, pend_next;
    logic [3:0]     cpu_count_reg;
    logic           done_reg, done_next;
    cuwm_result_t   result_reg, result_next;

    logic [14:0]    hist_mem [HDEPTH];
    logic           h_we;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [14:0]    h_wdata, h_rdata;

    logic [63:0]    lc_mem [LDEPTH];
    logic           lc_we;
    logic [LAW-1:0] lc_waddr, lc_raddr;
    logic [63:0]    lc_wdata, lc_rdata;

    logic           accept;
    logic           row_ok;
    logic [RW-1:0]  row_idx;
    logic [63:0]    tick_sel, delta;
    logic [65:0]    num_sel;
    logic [81:0]    div_t;
    logic [14:0]    q_avg;
    logic [RMW-1:0] rm_base;
    logic [2:0]     q_metric;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CPU_COUNT) ? {28'd0, cpu_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_count_reg <= CPU_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            cpu_count_reg <= pwdata[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hist_mem[h_waddr] <= h_wdata;
        end
        h_rdata <= hist_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lc_we)
        begin
            lc_mem[lc_waddr] <= lc_wdata;
        end
        lc_rdata <= lc_mem[lc_raddr];
    end

    always_comb
    begin
        row_ok  = 1'b0;
        row_idx = '0;
        if (cmd.row == ROW_TOTAL)
        begin
            row_ok = 1'b1;
        end
        else if (cmd.row == ROW_PARTITION)
        begin
            row_ok  = 1'b1;
            row_idx = RW'(ROWS - 1);
        end
        else if ((cmd.row <= cpu_count_reg) && (int'(cmd.row) <= MAX_CPUS))
        begin
            row_ok  = 1'b1;
            row_idx = RW'(cmd.row);
        end
    end

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    tick_sel = cmd_reg.user_ticks;
            2'd1:    tick_sel = cmd_reg.system_ticks;
            2'd2:    tick_sel = cmd_reg.idle_ticks;
            default: tick_sel = cmd_reg.iowait_ticks;
        endcase
    end

    assign delta    = tick_sel - lc_rdata;
    assign num_sel  = (idx_reg == METRIC_OVERALL) ? (tot_reg - {2'd0, d_reg[2]})
                                                  : {2'd0, d_reg[2'(idx_reg - 3'd1)]};
    assign div_t    = {16'd0, tot_reg} << bit_reg;
    // Every window is 4 times 15, 75 or 225, so the quarter sum is scaled by the
    // reciprocal with a 31-bit shift; this is exact over the whole sum range.
    assign q_avg    = 15'((51'(sum_reg[24:2]) * 51'(recip_reg)) >> 31);
    assign rm_base  = RMW'(ridx_reg) * RMW'(METRIC_COUNT);
    assign q_metric = (cmd.metric > METRIC_LAST) ? METRIC_OVERALL : cmd.metric;

    assign lc_raddr = {ridx_reg, idx_reg[1:0]};
    assign h_raddr  = {rm_reg, p_reg};

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        ridx_next   = ridx_reg;
        idx_next    = idx_reg;
        d_next      = d_reg;
        tot_next    = tot_reg;
        num_next    = num_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        bit_next    = bit_reg;
        slot_next   = slot_reg;
        p_next      = p_reg;
        rm_next     = rm_reg;
        cnt_next    = cnt_reg;
        recip_next  = recip_reg;
        sum_next    = sum_reg;
        pend_next   = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        h_we        = 1'b0;
        h_waddr     = {rm_base + RMW'(idx_reg), slot_reg};
        h_wdata     = q_reg;
        lc_we       = 1'b0;
        lc_waddr    = {ridx_reg, idx_reg[1:0]};
        lc_wdata    = tick_sel;

        if (pend_reg)
        begin
            sum_next = sum_reg + {10'd0, h_rdata};
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                h_we     = 1'b1;
                h_waddr  = clr_reg;
                h_wdata  = '0;
                lc_we    = (clr_reg < HAW'(LDEPTH));
                lc_waddr = clr_reg[LAW-1:0];
                lc_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HAW'(HDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd;
                    ridx_next = row_idx;
                    idx_next  = '0;
                    if (!row_ok)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: STATUS_BADROW, usage_avg: '0};
                    end
                    else if (cmd.req_type == REQ_SAMPLE)
                    begin
                        tot_next   = '0;
                        state_next = ST_LRD;
                    end
                    else
                    begin
                        rm_next  = RMW'(row_idx) * RMW'(METRIC_COUNT) + RMW'(q_metric);
                        p_next   = (slot_reg == '0) ? SW'(HISTORY_SLOTS - 1)
                                                    : slot_reg - 1'b1;
                        sum_next = '0;
                        case (cmd.window)
                            WIN_300:
                            begin
                                cnt_next   = COUNT_300;
                                recip_next = RECIP_300;
                            end
                            WIN_900:
                            begin
                                cnt_next   = COUNT_900;
                                recip_next = RECIP_900;
                            end
                            default:
                            begin
                                cnt_next   = COUNT_60;
                                recip_next = RECIP_60;
                            end
                        endcase
                        state_next = ST_QRD;
                    end
                end
            end
            ST_LRD:
            begin
                state_next = ST_LDELTA;
            end
            ST_LDELTA:
            begin
                lc_we                = 1'b1;
                d_next[idx_reg[1:0]] = delta;
                tot_next             = tot_reg + {2'd0, delta};
                if (idx_reg == 3'd3)
                begin
                    idx_next   = '0;
                    state_next = ST_MSEL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LRD;
                end
            end
            ST_MSEL:
            begin
                if (tot_reg == '0)
                begin
                    q_next     = (idx_reg == METRIC_IDLE) ? PCT_FULL : '0;
                    state_next = ST_WR;
                end
                else
                begin
                    // 25600 = 2^14 + 2^13 + 2^10, so the scaling is two shifted adds.
                    num_next   = num_sel;
                    n_next     = ({16'd0, num_sel} << 14) + ({16'd0, num_sel} << 13);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                n_next     = n_reg + ({16'd0, num_reg} << 10);
                q_next     = '0;
                bit_next   = 4'd14;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_t <= n_reg)
                begin
                    n_next          = n_reg - div_t;
                    q_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 4'd0)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                h_we = 1'b1;
                if (idx_reg == METRIC_LAST)
                begin
                    if (cmd_reg.end_of_tick)
                    begin
                        slot_next = (slot_reg == SW'(HISTORY_SLOTS - 1)) ? '0
                                                                         : slot_reg + 1'b1;
                    end
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_DONE, usage_avg: '0};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MSEL;
                end
            end
            ST_QRD:
            begin
                // One history word is read per cycle; its registered read data is added to the sum in the next cycle.
                pend_next = 1'b1;
                p_next    = (p_reg == '0) ? SW'(HISTORY_SLOTS - 1) : p_reg - 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == 10'd1)
                begin
                    state_next = ST_QDRAIN;
                end
            end
            ST_QDRAIN:
            begin
                state_next = ST_QDIV;
            end
            ST_QDIV:
            begin
                done_next   = 1'b1;
                result_next = '{status: STATUS_DONE, usage_avg: q_avg};
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            slot_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            bit_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            slot_reg  <= slot_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ridx_reg   <= ridx_next;
        d_reg      <= d_next;
        tot_reg    <= tot_next;
        num_reg    <= num_next;
        n_reg      <= n_next;
        q_reg      <= q_next;
        p_reg      <= p_next;
        rm_reg     <= rm_next;
        recip_reg  <= recip_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/cuwm_checker.sv =====
// Port-level checks for the CPU utilization window monitor, bound to the top level.
module cuwm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input cuwm_pkg::cuwm_cmd_t    cmd,
    input logic                   done,
    input cuwm_pkg::cuwm_result_t result
);
    import cuwm_pkg::*;

    // A rejected row never carries an average.
    a_badrow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_BADROW) |-> (result.usage_avg == '0))
        else $error("rejected word carries a nonzero average");

    // An average never exceeds one hundred percent.
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.usage_avg <= PCT_FULL))
        else $error("average above full scale");

    // The total row is always supported, so its work keeps the block busy.
    a_total_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.row == ROW_TOTAL) |=> (busy && !done))
        else $error("total row word finished too early");

endmodule

bind cpu_utilization_window_monitor cuwm_checker u_cuwm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
